@@ rtl/vcc_pkg.sv @@
`default_nettype none
package vcc_pkg;

	localparam logic [1:0] ACT_SPH  = 2'd0;
	localparam logic [1:0] ACT_CYL  = 2'd1;
	localparam logic [1:0] ACT_MAGT = 2'd2;
	localparam logic [1:0] ACT_MAG  = 2'd3;

	localparam int SQRT_STEPS = 32;
	localparam int ATAN_LEN   = 30;

	localparam logic [29:0] INV_TWO_PI = 30'd683565276;
	localparam logic signed [33:0] CORDIC_GAIN = 34'sh026DD3B6A;

	// one item inside the iteration chain
	typedef struct packed {
		logic [1:0]         action;
		logic               last;
		logic signed [31:0] a;
		logic signed [31:0] c;
		logic [1:0]         qb;
		logic [1:0]         qc;
		logic signed [33:0] xb;
		logic signed [33:0] yb;
		logic signed [33:0] zb;
		logic signed [33:0] xc;
		logic signed [33:0] yc;
		logic signed [33:0] zc;
		logic [63:0]        n;
		logic [63:0]        res;
	} vcc_iter_t;

	// arctangent of 2^-i in Q0.32 turns
	function automatic logic [29:0] atan_turn(input int i);
		logic [29:0] r;
		unique case (i)
			0: r = 30'h20000000;  1: r = 30'h12E4051E;  2: r = 30'h09FB385B;
			3: r = 30'h051111D4;  4: r = 30'h028B0D43;  5: r = 30'h0145D7E1;
			6: r = 30'h00A2F61E;  7: r = 30'h00517C55;  8: r = 30'h0028BE53;
			9: r = 30'h00145F2F;  10: r = 30'h000A2F98; 11: r = 30'h000517CC;
			12: r = 30'h00028BE6; 13: r = 30'h000145F3; 14: r = 30'h0000A2FA;
			15: r = 30'h0000517D; 16: r = 30'h000028BE; 17: r = 30'h0000145F;
			18: r = 30'h00000A30; 19: r = 30'h00000518; 20: r = 30'h0000028C;
			21: r = 30'h00000146; 22: r = 30'h000000A3; 23: r = 30'h00000051;
			24: r = 30'h00000029; 25: r = 30'h00000014; 26: r = 30'h0000000A;
			27: r = 30'h00000005; 28: r = 30'h00000003; 29: r = 30'h00000001;
			default: r = 30'h0;
		endcase
		return r;
	endfunction

	// add one half and drop 30 fraction bits, rounding to nearest with ties upward
	function automatic logic signed [41:0] rnd_q30(input logic signed [71:0] p);
		logic signed [71:0] t;
		t = (p + 72'sd536870912) >>> 30;
		return t[41:0];
	endfunction

	// clamp to signed 32 bits, flag in the top bit
	function automatic logic [32:0] sat32(input logic signed [41:0] v);
		logic [32:0] r;
		if (v > 42'sd2147483647) begin
			r = {1'b1, 32'h7FFFFFFF};
		end else if (v < -42'sd2147483648) begin
			r = {1'b1, 32'h80000000};
		end else begin
			r = {1'b0, v[31:0]};
		end
		return r;
	endfunction

endpackage
`default_nettype wire

@@ rtl/vcc_in_if.sv @@
`default_nettype none
interface vcc_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         action;
	logic signed [31:0] in_a;
	logic signed [31:0] in_b;
	logic signed [31:0] in_c;
	logic               in_last;

	modport source(output valid, action, in_a, in_b, in_c, in_last, input ready);
	modport sink(input valid, action, in_a, in_b, in_c, in_last, output ready);
endinterface
`default_nettype wire

@@ rtl/vcc_out_if.sv @@
`default_nettype none
interface vcc_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] out_x;
	logic signed [31:0] out_y;
	logic signed [31:0] out_z;
	logic               overflow;
	logic               out_last;

	modport source(output valid, out_x, out_y, out_z, overflow, out_last, input ready);
	modport sink(input valid, out_x, out_y, out_z, overflow, out_last, output ready);
endinterface
`default_nettype wire

@@ rtl/vector_coordinate_converter.sv @@
`default_nettype none
// streaming converter from spherical or cylindrical Q16.16 coordinates to Cartesian x, y, z,
// and magnitude unit for sqrt(x^2+y^2) and sqrt(x^2+y^2+z^2); one transaction per clock
// while the output register is empty or being taken (two front stages for angle scaling
// and squares, 32 iteration stages carrying the root digits and, in the first CORDIC_STEPS
// of them (at most 30), both CORDIC rotations side by side, three back stages for products,
// scaling and saturation); the whole pipeline advances whenever the output register is empty
// or being taken, so a stall holds every stage in place and nothing is dropped or repeated
module vector_coordinate_converter #(
	parameter int FRAC_BITS    = 16,
	parameter int CORDIC_STEPS = 20
) (
	input  wire logic clk,
	input  wire logic arst_n,
	vcc_in_if.sink    up,
	vcc_out_if.source dn
);

	// rotation steps beyond the table length are not carried out
	localparam int NC = (CORDIC_STEPS > vcc_pkg::ATAN_LEN) ? vcc_pkg::ATAN_LEN : CORDIC_STEPS;
	localparam int NI = vcc_pkg::SQRT_STEPS;

	logic               ce;
	logic               v_out;
	logic               v_c [0:NI];
	vcc_pkg::vcc_iter_t d_c [0:NI];

	// global advance: output register empty or its transaction completing
	assign ce       = !v_out || dn.ready;
	assign up.ready = ce;
	assign dn.valid = v_out;

	// angle to turns, quadrant split, sum of squares
	vcc_front #(
		.FRAC_BITS(FRAC_BITS)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.ce     (ce),
		.v_i    (up.valid),
		.action (up.action),
		.in_a   (up.in_a),
		.in_b   (up.in_b),
		.in_c   (up.in_c),
		.in_last(up.in_last),
		.v_o    (v_c[0]),
		.d_o    (d_c[0])
	);

	// one root digit per stage, and one cordic step for each angle in the first NC stages
	for (genvar g = 0; g < NI; g++) begin : g_step
		vcc_step #(
			.IDX(g),
			.NC (NC)
		) u_step (
			.clk   (clk),
			.arst_n(arst_n),
			.ce    (ce),
			.v_i   (v_c[g]),
			.d_i   (d_c[g]),
			.v_o   (v_c[g+1]),
			.d_o   (d_c[g+1])
		);
	end

	// sin/cos products, radius scaling, saturation, output register
	vcc_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.ce      (ce),
		.v_i     (v_c[NI]),
		.d_i     (d_c[NI]),
		.v_o     (v_out),
		.out_x   (dn.out_x),
		.out_y   (dn.out_y),
		.out_z   (dn.out_z),
		.overflow(dn.overflow),
		.out_last(dn.out_last)
	);

endmodule
`default_nettype wire

@@ rtl/vcc_front.sv @@
`default_nettype none
module vcc_front #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               ce,
	input  wire logic               v_i,
	input  wire logic [1:0]         action,
	input  wire logic signed [31:0] in_a,
	input  wire logic signed [31:0] in_b,
	input  wire logic signed [31:0] in_c,
	input  wire logic               in_last,
	output logic                    v_o,
	output vcc_pkg::vcc_iter_t      d_o
);

	typedef struct packed {
		logic [1:0]         action;
		logic               last;
		logic signed [31:0] a;
		logic signed [31:0] c;
		logic [31:0]        ph_b;
		logic [31:0]        ph_c;
		logic [63:0]        sqa;
		logic [63:0]        sqb;
		logic [63:0]        sqc;
	} vcc_front_t;

	logic signed [62:0] pb, pc;
	logic [31:0]        ua, ub, uc;
	vcc_front_t         f_d, f_s1;
	logic               v_s1;
	logic [1:0]         qb, qc;
	logic [31:0]        rb, rc;
	vcc_pkg::vcc_iter_t i_d;

	// angle in turns, squares for the magnitudes
	always_comb begin
		pb = $signed(63'(in_b)) * $signed(63'(vcc_pkg::INV_TWO_PI));
		pc = $signed(63'(in_c)) * $signed(63'(vcc_pkg::INV_TWO_PI));
		ua = in_a[31] ? 32'(-in_a) : 32'(in_a);
		ub = in_b[31] ? 32'(-in_b) : 32'(in_b);
		uc = in_c[31] ? 32'(-in_c) : 32'(in_c);
		f_d.action = action;
		f_d.last   = in_last;
		f_d.a      = in_a;
		f_d.c      = in_c;
		f_d.ph_b   = pb[FRAC_BITS+31:FRAC_BITS];
		f_d.ph_c   = pc[FRAC_BITS+31:FRAC_BITS];
		f_d.sqa    = 64'(ua) * 64'(ua);
		f_d.sqb    = 64'(ub) * 64'(ub);
		f_d.sqc    = (action == vcc_pkg::ACT_MAG) ? 64'(uc) * 64'(uc) : 64'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_o  <= 1'b0;
		end else if (ce) begin
			v_s1 <= v_i;
			v_o  <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			f_s1 <= f_d;
		end
	end

	// nearest quadrant and residual, seed of cordic and root
	always_comb begin
		qb = 2'((f_s1.ph_b + 32'h20000000) >> 30);
		qc = 2'((f_s1.ph_c + 32'h20000000) >> 30);
		rb = f_s1.ph_b - {qb, 30'd0};
		rc = f_s1.ph_c - {qc, 30'd0};
		i_d.action = f_s1.action;
		i_d.last   = f_s1.last;
		i_d.a      = f_s1.a;
		i_d.c      = f_s1.c;
		i_d.qb     = qb;
		i_d.qc     = qc;
		i_d.xb     = vcc_pkg::CORDIC_GAIN;
		i_d.yb     = '0;
		i_d.zb     = 34'($signed(rb));
		i_d.xc     = vcc_pkg::CORDIC_GAIN;
		i_d.yc     = '0;
		i_d.zc     = 34'($signed(rc));
		i_d.n      = f_s1.sqa + f_s1.sqb + f_s1.sqc;
		i_d.res    = '0;
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			d_o <= i_d;
		end
	end

endmodule
`default_nettype wire

@@ rtl/vcc_step.sv @@
`default_nettype none
module vcc_step #(
	parameter int IDX = 0,
	parameter int NC  = 20
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               ce,
	input  wire logic               v_i,
	input  wire vcc_pkg::vcc_iter_t d_i,
	output logic                    v_o,
	output vcc_pkg::vcc_iter_t      d_o
);

	localparam logic [63:0] BIT = 64'h1 << (62 - 2 * IDX);
	localparam logic signed [33:0] ATAN = 34'(vcc_pkg::atan_turn(IDX));

	vcc_pkg::vcc_iter_t nx;
	logic [63:0]        t;

	always_comb begin
		nx = d_i;
		if (IDX < NC) begin
			if (!d_i.zb[33]) begin
				nx.xb = d_i.xb - (d_i.yb >>> IDX);
				nx.yb = d_i.yb + (d_i.xb >>> IDX);
				nx.zb = d_i.zb - ATAN;
			end else begin
				nx.xb = d_i.xb + (d_i.yb >>> IDX);
				nx.yb = d_i.yb - (d_i.xb >>> IDX);
				nx.zb = d_i.zb + ATAN;
			end
			if (!d_i.zc[33]) begin
				nx.xc = d_i.xc - (d_i.yc >>> IDX);
				nx.yc = d_i.yc + (d_i.xc >>> IDX);
				nx.zc = d_i.zc - ATAN;
			end else begin
				nx.xc = d_i.xc + (d_i.yc >>> IDX);
				nx.yc = d_i.yc - (d_i.xc >>> IDX);
				nx.zc = d_i.zc + ATAN;
			end
		end
		// one root digit
		t = d_i.res + BIT;
		if (d_i.n >= t) begin
			nx.n   = d_i.n - t;
			nx.res = (d_i.res >> 1) + BIT;
		end else begin
			nx.res = d_i.res >> 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_o <= 1'b0;
		end else if (ce) begin
			v_o <= v_i;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			d_o <= nx;
		end
	end

endmodule
`default_nettype wire

@@ rtl/vcc_back.sv @@
`default_nettype none
module vcc_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               ce,
	input  wire logic               v_i,
	input  wire vcc_pkg::vcc_iter_t d_i,
	output logic                    v_o,
	output logic signed [31:0]      out_x,
	output logic signed [31:0]      out_y,
	output logic signed [31:0]      out_z,
	output logic                    overflow,
	output logic                    out_last
);

	typedef struct packed {
		logic [1:0]         action;
		logic               last;
		logic signed [31:0] a;
		logic signed [31:0] c;
		logic signed [41:0] x;
		logic signed [41:0] y;
		logic signed [41:0] z;
		logic [32:0]        mag;
	} vcc_prod_t;

	typedef struct packed {
		logic               last;
		logic signed [41:0] x;
		logic signed [41:0] y;
		logic signed [41:0] z;
	} vcc_res_t;

	logic signed [33:0] sb, cb, sc, cc, m_a, m_c, m_s, a34;
	logic signed [67:0] px, py, pz, qx, qy;
	vcc_prod_t          p_d, p_s1;
	vcc_res_t           r_d, r_s2;
	logic               v_s1, v_s2;
	logic               act0;
	logic [32:0]        sx, sy, sz;

	// quadrant rotation, first products
	always_comb begin
		unique case (d_i.qb)
			2'd0: begin cb = d_i.xb;  sb = d_i.yb;  end
			2'd1: begin cb = -d_i.yb; sb = d_i.xb;  end
			2'd2: begin cb = -d_i.xb; sb = -d_i.yb; end
			default: begin cb = d_i.yb; sb = -d_i.xb; end
		endcase
		unique case (d_i.qc)
			2'd0: begin cc = d_i.xc;  sc = d_i.yc;  end
			2'd1: begin cc = -d_i.yc; sc = d_i.xc;  end
			2'd2: begin cc = -d_i.xc; sc = -d_i.yc; end
			default: begin cc = d_i.yc; sc = -d_i.xc; end
		endcase
		act0 = (d_i.action == vcc_pkg::ACT_SPH);
		a34  = 34'(d_i.a);
		m_a  = act0 ? sb : a34;
		m_c  = act0 ? cc : cb;
		m_s  = act0 ? sc : sb;
		px   = m_a * m_c;
		py   = m_a * m_s;
		pz   = a34 * cb;
		p_d.action = d_i.action;
		p_d.last   = d_i.last;
		p_d.a      = d_i.a;
		p_d.c      = d_i.c;
		p_d.x      = vcc_pkg::rnd_q30(72'(px));
		p_d.y      = vcc_pkg::rnd_q30(72'(py));
		p_d.z      = vcc_pkg::rnd_q30(72'(pz));
		p_d.mag    = d_i.res[32:0];
	end

	// radius times inner products for spherical input; cylindrical z and magnitude passed through
	always_comb begin
		qx = 34'(p_s1.a) * $signed(p_s1.x[33:0]);
		qy = 34'(p_s1.a) * $signed(p_s1.y[33:0]);
		r_d.last = p_s1.last;
		unique case (p_s1.action)
			vcc_pkg::ACT_SPH: begin
				r_d.x = vcc_pkg::rnd_q30(72'(qx));
				r_d.y = vcc_pkg::rnd_q30(72'(qy));
				r_d.z = p_s1.z;
			end
			vcc_pkg::ACT_CYL: begin
				r_d.x = p_s1.x;
				r_d.y = p_s1.y;
				r_d.z = 42'(p_s1.c);
			end
			default: begin
				r_d.x = 42'(p_s1.mag);
				r_d.y = '0;
				r_d.z = '0;
			end
		endcase
	end

	always_comb begin
		sx = vcc_pkg::sat32(r_s2.x);
		sy = vcc_pkg::sat32(r_s2.y);
		sz = vcc_pkg::sat32(r_s2.z);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_o  <= 1'b0;
		end else if (ce) begin
			v_s1 <= v_i;
			v_s2 <= v_s1;
			v_o  <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			p_s1     <= p_d;
			r_s2     <= r_d;
			out_x    <= sx[31:0];
			out_y    <= sy[31:0];
			out_z    <= sz[31:0];
			overflow <= sx[32] | sy[32] | sz[32];
			out_last <= r_s2.last;
		end
	end

endmodule
`default_nettype wire

@@ verif/vcc_tb_if.sv @@
`default_nettype none
// testbench copies are not needed; the RTL interfaces are used directly
package vcc_tb_pkg;

	typedef struct {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic               ovf;
		logic               last;
	} vcc_result_t;
endpackage
`default_nettype wire

@@ verif/vector_coordinate_converter_tb.sv @@
`default_nettype none
module vector_coordinate_converter_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAC = 16;
	localparam int STEPS = 20;
	localparam int LATENCY = 37;
	localparam longint CYCLE_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	vcc_in_if  up();
	vcc_out_if dn();

	vector_coordinate_converter #(.FRAC_BITS(FRAC), .CORDIC_STEPS(STEPS)) DUT (
		.clk(clk), .arst_n(arst_n), .up(up), .dn(dn)
	);

	always #10 clk = ~clk;

	// idling modes for both sides, in percent
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_off = 0;      // long receiver hold-off, counted down in cycles
	int errors = 0;
	longint cycles = 0;
	vcc_tb_pkg::vcc_result_t expected_q[$];

	// arctangent table in Q0.32 turns
	function automatic longint atan_q32(input int i);
		longint t[30] = '{
			64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
			64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
			64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
			64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
			64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
			64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001};
		return t[i];
	endfunction

	// q30 product, half added, floor shift
	function automatic longint scale_q30(input longint a, input longint t);
		return (a * t + (64'sd1 <<< 29)) >>> 30;
	endfunction

	function automatic longint clamp32(input longint v, inout logic ovf);
		if (v > 64'sd2147483647) begin
			ovf = 1'b1;
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			ovf = 1'b1;
			return -64'sd2147483648;
		end
		return v;
	endfunction

	// sine and cosine in q30 from a fixed-point angle in radians
	task automatic sin_cos(input longint ang, output longint s, output longint c);
		logic [127:0] prod;
		logic [31:0] phase, resid;
		logic [1:0] quad;
		longint x, y, z, dx, dy;
		prod = 128'(ang) * 128'd683565276;
		phase = prod[FRAC +: 32];
		quad = 2'((phase + 32'h20000000) >> 30);
		resid = phase - (32'(quad) << 30);
		z = longint'(signed'(resid));
		x = 64'sh26DD3B6A;
		y = 0;
		for (int i = 0; i < STEPS && i < 30; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= atan_q32(i);
			end else begin
				x += dx; y -= dy; z += atan_q32(i);
			end
		end
		case (quad)
			2'd0: begin c = x;  s = y;  end
			2'd1: begin c = -y; s = x;  end
			2'd2: begin c = -x; s = -y; end
			default: begin c = y; s = -x; end
		endcase
	endtask

	function automatic logic [63:0] int_root(input logic [63:0] n);
		logic [63:0] res, b;
		res = 0;
		b = 64'd1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (n >= res + b) begin
				n -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	// expected conversion of one transaction
	task automatic convert_vector(input logic [1:0] act, input logic signed [31:0] a,
			input logic signed [31:0] b, input logic signed [31:0] c, input logic last,
			output vcc_tb_pkg::vcc_result_t r);
		longint st, ct, sp, cp, ra;
		logic [63:0] ua, ub, uc, sum;
		logic ovf;
		ovf = 1'b0;
		ra = a;
		r.y = 0;
		r.z = 0;
		case (act)
			vcc_pkg::ACT_SPH: begin
				sin_cos(b, st, ct);
				sin_cos(c, sp, cp);
				r.x = 32'(clamp32(scale_q30(ra, scale_q30(st, cp)), ovf));
				r.y = 32'(clamp32(scale_q30(ra, scale_q30(st, sp)), ovf));
				r.z = 32'(clamp32(scale_q30(ra, ct), ovf));
			end
			vcc_pkg::ACT_CYL: begin
				sin_cos(b, sp, cp);
				r.x = 32'(clamp32(scale_q30(ra, cp), ovf));
				r.y = 32'(clamp32(scale_q30(ra, sp), ovf));
				r.z = c;
			end
			default: begin
				ua = a < 0 ? 64'(-longint'(a)) : 64'(a);
				ub = b < 0 ? 64'(-longint'(b)) : 64'(b);
				uc = c < 0 ? 64'(-longint'(c)) : 64'(c);
				sum = ua * ua + ub * ub;
				if (act == vcc_pkg::ACT_MAG) sum += uc * uc;
				r.x = 32'(clamp32(longint'(int_root(sum)), ovf));
			end
		endcase
		r.ovf = ovf;
		r.last = last;
	endtask

	// source side: drive one transaction and wait for its acceptance
	task automatic send_vector(input logic [1:0] act, input logic signed [31:0] a,
			input logic signed [31:0] b, input logic signed [31:0] c, input logic last);
		vcc_tb_pkg::vcc_result_t r;
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			up.valid <= 1'b0;
			@(posedge clk);
		end
		up.valid <= 1'b1;
		up.action <= act;
		up.in_a <= a;
		up.in_b <= b;
		up.in_c <= c;
		up.in_last <= last;
		convert_vector(act, a, b, c, last, r);
		do @(posedge clk); while (!up.ready);
		expected_q.push_back(r);
	endtask

	task automatic go_idle();
		up.valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic signed [31:0] rand_word();
		case ($urandom_range(5))
			0: return 32'sh7FFFFFFF;
			1: return 32'sh80000000;
			2: return 32'(signed'(16'($urandom)));
			3: return 32'($urandom_range(32'h00200000)) - 32'sh00100000;
			default: return 32'($urandom);
		endcase
	endfunction

	// random transactions, mixing extreme, small and full-range words
	task automatic send_random(input int count);
		logic [1:0] act;
		for (int i = 0; i < count; i++) begin
			act = 2'($urandom);
			send_vector(act, rand_word(), rand_word(), rand_word(), 1'(i % 16 == 15 || $urandom_range(1)));
		end
		go_idle();
	endtask

	task automatic test_extremes();
		logic signed [31:0] v[5] = '{32'sh7FFFFFFF, 32'sh80000000, 0, 32'sh00010000, -32'sh1};
		for (int k = 0; k < 4; k++) begin
			send_vector(2'(k), v[0], v[0], v[0], 1'b1);
			send_vector(2'(k), v[1], v[1], v[1], 1'b0);
			send_vector(2'(k), v[2], v[2], v[2], 1'b1);
			send_vector(2'(k), v[3], v[4], v[3], 1'b0);
		end
		// negative radius and a very large angle
		send_vector(vcc_pkg::ACT_CYL, -32'sh00050000, 32'sh40000000, 32'sh00030000, 1'b1);
		send_vector(vcc_pkg::ACT_SPH, -32'sh00020000, 32'sh7FFF0000, 32'sh80010000, 1'b0);
		// overflow from a large magnitude
		send_vector(vcc_pkg::ACT_MAG, 32'sh80000000, 32'sh80000000, 32'sh80000000, 1'b1);
		// quadrant edges near pi/2 and pi
		send_vector(vcc_pkg::ACT_CYL, 32'sh00010000, 32'sh0001921F, 0, 1'b0);
		send_vector(vcc_pkg::ACT_CYL, 32'sh00010000, 32'sh0003243F, 0, 1'b1);
		go_idle();
	endtask

	task automatic test_idling();
		int s[4] = '{0, 58, 0, 32};
		int r[4] = '{0, 0, 58, 32};
		for (int p = 0; p < 4; p++) begin
			send_idle_pct = s[p];
			recv_stall_pct = r[p];
			send_random(300);
		end
		send_idle_pct = 0;
		recv_stall_pct = 0;
	endtask

	// receiver holds off long enough that the pipeline backs up into the input
	task automatic test_backpressure();
		hold_off = 120;
		send_random(150);
		send_idle_pct = 20;
		recv_stall_pct = 20;
		send_random(150);
		send_idle_pct = 0;
		recv_stall_pct = 0;
	endtask

	// sink side: random stalls plus the long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dn.ready <= 1'b0;
		end else if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			dn.ready <= 1'b0;
		end else begin
			dn.ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
		end
	end

	// compare each accepted result against the oldest expectation
	always @(posedge clk) begin
		vcc_tb_pkg::vcc_result_t e;
		if (arst_n && dn.valid && dn.ready) begin
			if (expected_q.size() == 0) begin
				$error("unexpected result transaction x=%0d", dn.out_x);
				errors++;
			end else begin
				e = expected_q.pop_front();
				if (dn.out_x !== e.x) begin
					$error("out_x expected %0d actual %0d", e.x, dn.out_x); errors++;
				end
				if (dn.out_y !== e.y) begin
					$error("out_y expected %0d actual %0d", e.y, dn.out_y); errors++;
				end
				if (dn.out_z !== e.z) begin
					$error("out_z expected %0d actual %0d", e.z, dn.out_z); errors++;
				end
				if (dn.overflow !== e.ovf) begin
					$error("overflow expected %0b actual %0b", e.ovf, dn.overflow); errors++;
				end
				if (dn.out_last !== e.last) begin
					$error("out_last expected %0b actual %0b", e.last, dn.out_last); errors++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL vector_coordinate_converter");
			$finish;
		end
	end

	initial begin
		int drain;
		up.valid = 1'b0;
		up.action = vcc_pkg::ACT_SPH;
		up.in_a = 0;
		up.in_b = 0;
		up.in_c = 0;
		up.in_last = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_idling();
		test_backpressure();
		// drain the pipeline, then allow its latency once more
		drain = 0;
		while (expected_q.size() != 0 && drain < 100000) begin
			@(posedge clk);
			drain++;
		end
		repeat (LATENCY + 10) @(posedge clk);
		if (errors == 0 && expected_q.size() == 0) begin
			$display("PASS vector_coordinate_converter");
		end else begin
			$display("FAIL vector_coordinate_converter");
		end
		$finish;
	end
endmodule
`default_nettype wire

@@ filelist.f @@
rtl/vcc_pkg.sv
rtl/vcc_in_if.sv
rtl/vcc_out_if.sv
rtl/vcc_front.sv
rtl/vcc_step.sv
rtl/vcc_back.sv
rtl/vector_coordinate_converter.sv
verif/vcc_tb_if.sv
verif/vector_coordinate_converter_tb.sv
